// ===== sv/ekp_pkg.sv =====
// package: frame constants, job and pin types for the encoder/key framer
`default_nettype none

package ekp_pkg;

  localparam logic [7:0] FRAME_SOF = 8'h7E;
  localparam logic [7:0] FRAME_EOF = 8'hEF;
  localparam logic [7:0] LEN_NO_PARAM = 8'h03;
  localparam logic [7:0] LEN_ONE_PARAM = 8'h04;
  localparam logic [7:0] CMD_VOLUME = 8'h31;
  localparam logic [7:0] CMD_PLAY_PAUSE = 8'h1C;
  localparam logic [7:0] CMD_NEXT = 8'h13;
  localparam logic [7:0] CMD_PREV = 8'h14;

  localparam logic [7:0] CEILING_RESET = 8'd30;
  localparam logic [7:0] VOLUME_RESET = 8'd20;
  localparam logic [15:0] TRACK_RESET = 16'd1;
  localparam logic [15:0] TRACK_MAX = 16'hFFFF;

  localparam int NUM_FRAMES = 5;

  // frame slots in transmit order
  localparam int FR_VOLUME = 0;
  localparam int FR_SWITCH = 1;
  localparam int FR_PLAY = 2;
  localparam int FR_NEXT = 3;
  localparam int FR_PREV = 4;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_CLK_FIRST = 2'd1,
    PHASE_DT_FIRST = 2'd2,
    PHASE_SPARE = 2'd3
  } phase_t;

  typedef struct packed {
    logic enc_clk;
    logic enc_dt;
    logic sw;
    logic sw_recheck;
    logic play;
    logic play_recheck;
    logic next;
    logic next_recheck;
    logic prev;
    logic prev_recheck;
  } pins_t;

  typedef struct packed {
    logic [NUM_FRAMES-1:0] mask;
    logic [7:0] vol_sent;
    logic playing;
    logic [7:0] volume;
    logic [15:0] track;
  } job_t;

endpackage

`default_nettype wire

// ===== sv/ekp_tick.sv =====
// tick logic: edge detection, encoder tracker, volume/track/playing state, frame mask
`default_nettype none

module ekp_tick (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [7:0]    cfg_wr_data,
  input  wire ekp_pkg::pins_t pins,
  input  wire logic          accept,
  output ekp_pkg::job_t      job,
  output logic               job_load
);
  import ekp_pkg::*;

  logic       clk_before_r, dt_before_r, switch_before_r;
  logic [2:0] keys_before_r;
  phase_t     phase_r, phase_nxt;
  logic [7:0] volume_r, volume_nxt;
  logic [15:0] track_r, track_nxt;
  logic       playing_r, playing_nxt;
  logic [7:0] ceiling_r;

  phase_t     phase_mid;
  logic       vol_fire, sw_fire, play_fire, next_fire, prev_fire;
  logic [8:0] vol_up;
  logic [15:0] track_mid;

  always_comb begin
    phase_mid = phase_r;
    if (phase_r == PHASE_IDLE) begin
      if (!pins.enc_clk && clk_before_r) begin
        phase_mid = PHASE_CLK_FIRST;
      end else if (!pins.enc_dt && dt_before_r) begin
        phase_mid = PHASE_DT_FIRST;
      end
    end
    vol_fire = (phase_mid != PHASE_IDLE) && pins.enc_clk && pins.enc_dt;
    phase_nxt = vol_fire ? PHASE_IDLE : phase_mid;

    vol_up = {1'b0, volume_r} + 9'd1;
    volume_nxt = volume_r;
    if (vol_fire) begin
      if (phase_mid == PHASE_CLK_FIRST) begin
        volume_nxt = (vol_up > {1'b0, ceiling_r}) ? ceiling_r : vol_up[7:0];
      end else if (volume_r != 8'd0) begin
        volume_nxt = volume_r - 8'd1;
      end
    end

    sw_fire = !pins.sw && switch_before_r && !pins.sw_recheck;
    play_fire = !pins.play && keys_before_r[0] && !pins.play_recheck;
    next_fire = !pins.next && keys_before_r[1] && !pins.next_recheck;
    prev_fire = !pins.prev && keys_before_r[2] && !pins.prev_recheck;

    playing_nxt = (next_fire || prev_fire) ? 1'b1 : (playing_r ^ sw_fire ^ play_fire);

    track_mid = (next_fire && track_r != TRACK_MAX) ? track_r + 16'd1 : track_r;
    track_nxt = (prev_fire && track_mid > 16'd1) ? track_mid - 16'd1 : track_mid;

    job.mask = '0;
    job.mask[FR_VOLUME] = vol_fire;
    job.mask[FR_SWITCH] = sw_fire;
    job.mask[FR_PLAY] = play_fire;
    job.mask[FR_NEXT] = next_fire;
    job.mask[FR_PREV] = prev_fire;
    job.vol_sent = (volume_nxt > ceiling_r) ? ceiling_r : volume_nxt;
    job.playing = playing_nxt;
    job.volume = volume_nxt;
    job.track = track_nxt;
    job_load = accept && (job.mask != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_before_r <= 1'b1;
      dt_before_r <= 1'b1;
      switch_before_r <= 1'b1;
      keys_before_r <= 3'b111;
      phase_r <= PHASE_IDLE;
      volume_r <= VOLUME_RESET;
      track_r <= TRACK_RESET;
      playing_r <= 1'b1;
      ceiling_r <= CEILING_RESET;
    end else begin
      if (cfg_wr_en) begin
        ceiling_r <= cfg_wr_data;
      end
      if (accept) begin
        clk_before_r <= pins.enc_clk;
        dt_before_r <= pins.enc_dt;
        switch_before_r <= pins.sw;
        keys_before_r <= {pins.prev, pins.next, pins.play};
        phase_r <= phase_nxt;
        volume_r <= volume_nxt;
        track_r <= track_nxt;
        playing_r <= playing_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/ekp_serializer.sv =====
// frame serializer: job register, byte sequencer and output word register
`default_nettype none

module ekp_serializer (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ekp_pkg::job_t job_in,
  input  wire logic          job_load,
  output logic               job_free,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_frame_byte,
  output logic               out_frame_end,
  output logic               out_run_end,
  output logic               out_playing_now,
  output logic [7:0]         out_volume_now,
  output logic [15:0]        out_track_now
);
  import ekp_pkg::*;

  localparam logic [2:0] IDX_SOF = 3'd0;
  localparam logic [2:0] IDX_LEN = 3'd1;
  localparam logic [2:0] IDX_CMD = 3'd2;
  localparam logic [2:0] IDX_B3 = 3'd3;
  localparam logic [2:0] IDX_B4 = 3'd4;
  localparam logic [2:0] IDX_B5 = 3'd5;

  job_t       job_r;
  logic       job_valid_r;
  logic [2:0] idx_r;

  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       frame_end_r, run_end_r, playing_r;
  logic [7:0] volume_r;
  logic [15:0] track_r;

  logic       is_vol, at_end, last_of_job, load_out;
  logic [7:0] cmd, cur_byte;
  logic [NUM_FRAMES-1:0] mask_rest;

  always_comb begin
    is_vol = job_r.mask[FR_VOLUME];
    if (job_r.mask[FR_VOLUME]) begin
      cmd = CMD_VOLUME;
    end else if (job_r.mask[FR_SWITCH] || job_r.mask[FR_PLAY]) begin
      cmd = CMD_PLAY_PAUSE;
    end else if (job_r.mask[FR_NEXT]) begin
      cmd = CMD_NEXT;
    end else begin
      cmd = CMD_PREV;
    end
    mask_rest = job_r.mask & (job_r.mask - NUM_FRAMES'(1));
    at_end = (idx_r == (is_vol ? IDX_B5 : IDX_B4));
    last_of_job = at_end && (mask_rest == '0);

    case (idx_r)
      IDX_SOF: cur_byte = FRAME_SOF;
      IDX_LEN: cur_byte = is_vol ? LEN_ONE_PARAM : LEN_NO_PARAM;
      IDX_CMD: cur_byte = cmd;
      IDX_B3:  cur_byte = is_vol ? job_r.vol_sent : (LEN_NO_PARAM ^ cmd);
      IDX_B4:  cur_byte = is_vol ? (LEN_ONE_PARAM ^ cmd ^ job_r.vol_sent) : FRAME_EOF;
      default: cur_byte = FRAME_EOF;
    endcase

    load_out = job_valid_r && (!out_valid_r || !out_stall);
    job_free = !job_valid_r || (load_out && last_of_job);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r <= IDX_SOF;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= load_out || (out_valid_r && out_stall);
      if (job_load) begin
        job_valid_r <= 1'b1;
        idx_r <= IDX_SOF;
      end else if (load_out) begin
        if (last_of_job) begin
          job_valid_r <= 1'b0;
          idx_r <= IDX_SOF;
        end else if (at_end) begin
          idx_r <= IDX_SOF;
        end else begin
          idx_r <= idx_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job_in;
    end else if (load_out && at_end) begin
      job_r.mask <= mask_rest;
    end
    if (load_out) begin
      byte_r <= cur_byte;
      frame_end_r <= at_end;
      run_end_r <= last_of_job;
      playing_r <= job_r.playing;
      volume_r <= job_r.volume;
      track_r <= job_r.track;
    end
  end

  assign out_valid = out_valid_r;
  assign out_frame_byte = byte_r;
  assign out_frame_end = frame_end_r;
  assign out_run_end = run_end_r;
  assign out_playing_now = playing_r;
  assign out_volume_now = volume_r;
  assign out_track_now = track_r;

endmodule

`default_nettype wire

// ===== sv/encoder_keys_to_player_frames.sv =====
// top level: encoder and key poll ticks in, player command frame words out
// the first word of an accepted tick goes through the job register, then the output word register
// input: a tick producing n words (n up to 26) stalls the input until its last word is loaded,
//   the serializer emitting one word per cycle while out_stall is low; quiet ticks load no job
// reset: synchronous active low, restores pin history, volume 20, track 1,
//   playing set and ceiling 30; no clearing pass
`default_nettype none

module encoder_keys_to_player_frames (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_enc_clk_level,
  input  wire logic        in_enc_dt_level,
  input  wire logic        in_enc_switch_level,
  input  wire logic        in_enc_switch_recheck,
  input  wire logic        in_key_play_level,
  input  wire logic        in_key_play_recheck,
  input  wire logic        in_key_next_level,
  input  wire logic        in_key_next_recheck,
  input  wire logic        in_key_prev_level,
  input  wire logic        in_key_prev_recheck,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_frame_byte,
  output logic             out_frame_end,
  output logic             out_run_end,
  output logic             out_playing_now,
  output logic [7:0]       out_volume_now,
  output logic [15:0]      out_track_now
);
  import ekp_pkg::*;

  pins_t pins;
  job_t  job;
  logic  job_load, job_free, accept;

  assign pins = '{enc_clk: in_enc_clk_level, enc_dt: in_enc_dt_level,
                  sw: in_enc_switch_level, sw_recheck: in_enc_switch_recheck,
                  play: in_key_play_level, play_recheck: in_key_play_recheck,
                  next: in_key_next_level, next_recheck: in_key_next_recheck,
                  prev: in_key_prev_level, prev_recheck: in_key_prev_recheck};

  assign in_stall = !job_free;
  assign accept = in_valid && job_free;

  ekp_tick u_tick (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pins        (pins),
    .accept      (accept),
    .job         (job),
    .job_load    (job_load)
  );

  ekp_serializer u_ser (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_in          (job),
    .job_load        (job_load),
    .job_free        (job_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_byte  (out_frame_byte),
    .out_frame_end   (out_frame_end),
    .out_run_end     (out_run_end),
    .out_playing_now (out_playing_now),
    .out_volume_now  (out_volume_now),
    .out_track_now   (out_track_now)
  );

  // closing word of a frame is always the end marker
  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_frame_byte == FRAME_EOF)
    else $error("frame end word is not the end marker");

  a_run_end_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_end |-> out_frame_end)
    else $error("run end outside a frame end");

  // a new frame of the same tick follows at once with its start marker
  a_next_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_frame_end && !out_run_end
    |=> out_valid && out_frame_byte == FRAME_SOF)
    else $error("frame of the same tick does not follow with start marker");

  a_track_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_track_now != 16'd0)
    else $error("track number reached zero");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the encoder and key command framer: poll ticks checked word by word against a predictor
`timescale 1ns / 100ps

module tb_top;
  import ekp_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TICK_WORDS_MAX = 26;

  localparam logic [3:0] KEY_SWITCH = 4'b0001;
  localparam logic [3:0] KEY_PLAY = 4'b0010;
  localparam logic [3:0] KEY_NEXT = 4'b0100;
  localparam logic [3:0] KEY_PREV = 4'b1000;
  localparam logic [3:0] ALL_KEYS = 4'b1111;
  localparam logic [3:0] NO_KEYS = 4'b0000;

  typedef struct packed {
    logic [7:0]  data;
    logic        frame_last;
    logic        tick_last;
    logic        playing;
    logic [7:0]  volume;
    logic [15:0] track;
  } frame_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        out_stall = 1'b0;
  pins_t       cur_tick = '1;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_frame_byte;
  logic        out_frame_end;
  logic        out_run_end;
  logic        out_playing_now;
  logic [7:0]  out_volume_now;
  logic [15:0] out_track_now;

  pins_t       pending_ticks[$];
  frame_word_t frame_words_due[$];
  int          ticks_queued = 0;
  int          ticks_taken = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          in_gap = 0;
  int          out_wait = 0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  logic        in_calm = 1'b0;
  logic        out_calm = 1'b0;
  logic        rush = 1'b0;

  // predictor state
  logic        clk_was = 1'b1;
  logic        dt_was = 1'b1;
  logic        sw_was = 1'b1;
  logic [2:0]  keys_was = 3'b111;
  phase_t      turn = PHASE_IDLE;
  logic [7:0]  volume = VOLUME_RESET;
  logic [7:0]  ceiling = CEILING_RESET;
  logic [15:0] track = TRACK_RESET;
  logic        playing = 1'b1;
  logic [7:0]  tick_bytes [TICK_WORDS_MAX];
  logic        tick_marks [TICK_WORDS_MAX];
  int          tick_len;

  encoder_keys_to_player_frames u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_enc_clk_level      (cur_tick.enc_clk),
    .in_enc_dt_level       (cur_tick.enc_dt),
    .in_enc_switch_level   (cur_tick.sw),
    .in_enc_switch_recheck (cur_tick.sw_recheck),
    .in_key_play_level     (cur_tick.play),
    .in_key_play_recheck   (cur_tick.play_recheck),
    .in_key_next_level     (cur_tick.next),
    .in_key_next_recheck   (cur_tick.next_recheck),
    .in_key_prev_level     (cur_tick.prev),
    .in_key_prev_recheck   (cur_tick.prev_recheck),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_frame_byte        (out_frame_byte),
    .out_frame_end         (out_frame_end),
    .out_run_end           (out_run_end),
    .out_playing_now       (out_playing_now),
    .out_volume_now        (out_volume_now),
    .out_track_now         (out_track_now)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic emit(input logic [7:0] b, input logic mark);
    tick_bytes[tick_len] = b;
    tick_marks[tick_len] = mark;
    tick_len++;
  endtask

  task automatic emit_short(input logic [7:0] cmd);
    emit(FRAME_SOF, 1'b0);
    emit(LEN_NO_PARAM, 1'b0);
    emit(cmd, 1'b0);
    emit(LEN_NO_PARAM ^ cmd, 1'b0);
    emit(FRAME_EOF, 1'b1);
  endtask

  task automatic predict_frames(input pins_t p);
    logic [8:0]  raised;
    logic [7:0]  sent;
    frame_word_t w;
    int          k;
    tick_len = 0;
    if (turn == PHASE_IDLE) begin
      if (!p.enc_clk && clk_was) turn = PHASE_CLK_FIRST;
      else if (!p.enc_dt && dt_was) turn = PHASE_DT_FIRST;
    end
    if (turn != PHASE_IDLE && p.enc_clk && p.enc_dt) begin
      if (turn == PHASE_CLK_FIRST) begin
        raised = {1'b0, volume} + 9'd1;
        volume = (raised > {1'b0, ceiling}) ? ceiling : raised[7:0];
      end else if (volume != 8'd0) begin
        volume = volume - 8'd1;
      end
      sent = (volume > ceiling) ? ceiling : volume;
      emit(FRAME_SOF, 1'b0);
      emit(LEN_ONE_PARAM, 1'b0);
      emit(CMD_VOLUME, 1'b0);
      emit(sent, 1'b0);
      emit(LEN_ONE_PARAM ^ CMD_VOLUME ^ sent, 1'b0);
      emit(FRAME_EOF, 1'b1);
      turn = PHASE_IDLE;
    end
    clk_was = p.enc_clk;
    dt_was = p.enc_dt;
    if (!p.sw && sw_was && !p.sw_recheck) begin
      emit_short(CMD_PLAY_PAUSE);
      playing = ~playing;
    end
    sw_was = p.sw;
    if (!p.play && keys_was[0] && !p.play_recheck) begin
      emit_short(CMD_PLAY_PAUSE);
      playing = ~playing;
    end
    if (!p.next && keys_was[1] && !p.next_recheck) begin
      emit_short(CMD_NEXT);
      if (track != TRACK_MAX) track = track + 16'd1;
      playing = 1'b1;
    end
    if (!p.prev && keys_was[2] && !p.prev_recheck) begin
      emit_short(CMD_PREV);
      if (track > 16'd1) track = track - 16'd1;
      playing = 1'b1;
    end
    keys_was = {p.prev, p.next, p.play};
    for (k = 0; k < tick_len; k++) begin
      w.data = tick_bytes[k];
      w.frame_last = tick_marks[k];
      w.tick_last = (k == tick_len - 1);
      w.playing = playing;
      w.volume = volume;
      w.track = track;
      frame_words_due.push_back(w);
    end
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s expected %0h got %0h", field, want, got);
      mismatches++;
    end
  endtask

  // input side
  always @(negedge clk) begin : driver
    int gap;
    if (rst_n) begin
      if (in_valid && in_taken) begin
        if ($urandom_range(0, 15) == 0) in_calm = ~in_calm;
        gap = (in_calm || rush) ? 0 : $urandom_range(0, 4);
        if (gap == 0 && pending_ticks.size() != 0) begin
          cur_tick <= pending_ticks.pop_front();
        end else begin
          in_valid <= 1'b0;
          in_gap <= gap;
        end
      end else if (!in_valid) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
        end else if (pending_ticks.size() != 0) begin
          cur_tick <= pending_ticks.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin : receiver
    int hold;
    if (rst_n) begin
      if (out_taken) begin
        if ($urandom_range(0, 15) == 0) out_calm = ~out_calm;
        hold = (out_calm || rush) ? 0 : $urandom_range(0, 4);
        out_stall <= (hold != 0);
        out_wait <= (hold != 0) ? hold - 1 : 0;
      end else if (out_wait != 0) begin
        out_wait <= out_wait - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    frame_word_t due;
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      out_taken <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        if (frame_words_due.size() == 0) begin
          $error("unexpected word %02h", out_frame_byte);
          mismatches++;
        end else begin
          due = frame_words_due.pop_front();
          check_field("frame_byte", 16'(due.data), 16'(out_frame_byte));
          check_field("frame_end", 16'(due.frame_last), 16'(out_frame_end));
          check_field("run_end", 16'(due.tick_last), 16'(out_run_end));
          check_field("playing_now", 16'(due.playing), 16'(out_playing_now));
          check_field("volume_now", 16'(due.volume), 16'(out_volume_now));
          check_field("track_now", due.track, out_track_now);
        end
      end
      if (in_valid && !in_stall) begin
        predict_frames(cur_tick);
        ticks_taken++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic pins_t enc_pins(input logic c, input logic d);
    pins_t p;
    p = '1;
    p.enc_clk = c;
    p.enc_dt = d;
    return p;
  endfunction

  function automatic pins_t key_pins(input logic [3:0] pressed, input logic [3:0] rechecks);
    pins_t p;
    p = '1;
    p.sw = ~pressed[0];
    p.sw_recheck = rechecks[0];
    p.play = ~pressed[1];
    p.play_recheck = rechecks[1];
    p.next = ~pressed[2];
    p.next_recheck = rechecks[2];
    p.prev = ~pressed[3];
    p.prev_recheck = rechecks[3];
    return p;
  endfunction

  task automatic queue_tick(input pins_t p);
    pending_ticks.push_back(p);
    ticks_queued++;
  endtask

  task automatic drain();
    while (ticks_taken != ticks_queued || frame_words_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_ceiling(input logic [7:0] value);
    drain();
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    ceiling = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic add_random_sequence();
    logic [3:0] which;
    logic [3:0] rechecks;
    logic [9:0] noise;
    logic       up;
    which = 4'($urandom_range(1, 15));
    rechecks = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : NO_KEYS;
    up = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        if (up) begin
          queue_tick(enc_pins(1'b0, 1'b1));
          queue_tick(enc_pins(1'b0, 1'b0));
          queue_tick(enc_pins(1'b1, 1'b0));
        end else begin
          queue_tick(enc_pins(1'b1, 1'b0));
          queue_tick(enc_pins(1'b0, 1'b0));
          queue_tick(enc_pins(1'b0, 1'b1));
        end
        queue_tick(enc_pins(1'b1, 1'b1));
      end
      3: begin
        queue_tick(up ? enc_pins(1'b0, 1'b1) : enc_pins(1'b1, 1'b0));
        queue_tick(enc_pins(1'b1, 1'b1));
      end
      4, 5, 6: begin
        queue_tick(key_pins(which, rechecks));
        queue_tick(key_pins(NO_KEYS, 4'($urandom_range(0, 15))));
      end
      7: begin
        queue_tick(up ? enc_pins(1'b0, 1'b1) : enc_pins(1'b1, 1'b0));
        queue_tick(key_pins(which, rechecks));
        queue_tick(key_pins(NO_KEYS, 4'($urandom_range(0, 15))));
      end
      8: begin
        repeat ($urandom_range(1, 3)) begin
          noise = 10'($urandom_range(0, 1023));
          queue_tick(noise);
        end
      end
      default: begin
        // encoder chatter
        repeat ($urandom_range(2, 4)) begin
          queue_tick(enc_pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end
      end
    endcase
  endtask

  task automatic random_phase(input int count);
    int stop_at;
    stop_at = ticks_queued + count;
    while (ticks_queued < stop_at) add_random_sequence();
  endtask

  initial begin : sequencer
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    queue_tick('1);
    queue_tick(enc_pins(1'b0, 1'b1));
    queue_tick(enc_pins(1'b0, 1'b0));
    queue_tick(enc_pins(1'b1, 1'b0));
    queue_tick(enc_pins(1'b1, 1'b1));
    queue_tick(enc_pins(1'b1, 1'b0));
    queue_tick(enc_pins(1'b0, 1'b0));
    queue_tick(enc_pins(1'b0, 1'b1));
    queue_tick(enc_pins(1'b1, 1'b1));
    // volume step and every button on one tick
    queue_tick(enc_pins(1'b0, 1'b1));
    queue_tick(key_pins(ALL_KEYS, NO_KEYS));
    queue_tick(key_pins(ALL_KEYS, NO_KEYS));
    queue_tick(key_pins(NO_KEYS, ALL_KEYS));
    // bounce rejected by the recheck
    queue_tick(key_pins(ALL_KEYS, ALL_KEYS));
    queue_tick(key_pins(NO_KEYS, NO_KEYS));
    // previous at the first track
    queue_tick(key_pins(KEY_PREV, NO_KEYS));
    queue_tick(key_pins(NO_KEYS, ALL_KEYS));
    queue_tick(enc_pins(1'b0, 1'b0));
    queue_tick(enc_pins(1'b1, 1'b1));
    queue_tick(enc_pins(1'b1, 1'b0));
    queue_tick(enc_pins(1'b1, 1'b1));
    queue_tick(key_pins(KEY_SWITCH | KEY_PLAY, NO_KEYS));
    queue_tick(key_pins(NO_KEYS, NO_KEYS));

    set_ceiling(8'd255);
    random_phase(70);
    set_ceiling(8'd3);
    random_phase(65);
    set_ceiling(8'd0);
    random_phase(55);
    set_ceiling(8'($urandom_range(1, 254)));
    random_phase(65);

    // back to back ticks with no idling on either side
    set_ceiling(8'd255);
    rush = 1'b1;
    repeat (8) begin
      queue_tick(enc_pins(1'b0, 1'b1));
      queue_tick(enc_pins(1'b1, 1'b1));
    end
    repeat (4) begin
      queue_tick(key_pins(KEY_NEXT, NO_KEYS));
      queue_tick(key_pins(NO_KEYS, NO_KEYS));
    end
    queue_tick(key_pins(KEY_PREV, NO_KEYS));
    queue_tick(key_pins(NO_KEYS, NO_KEYS));
    drain();
    rush = 1'b0;

    // ceiling lowered to 10, possibly below the current volume
    set_ceiling(8'd10);
    queue_tick(enc_pins(1'b1, 1'b0));
    queue_tick(enc_pins(1'b1, 1'b1));
    queue_tick(enc_pins(1'b0, 1'b1));
    queue_tick(enc_pins(1'b1, 1'b1));
    drain();

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
